// File: design/vfcm_pkg.sv
package vfcm_pkg;

  localparam int COORD_W    = 5;
  localparam int MAT_W      = 16;
  localparam int VOX_W      = MAT_W + 1;
  localparam int VS_W       = 16;
  localparam int ORIGIN_W   = 21;
  localparam int VCOUNT_W   = 20;
  localparam int DIR_W      = 3;
  localparam int NUM_DIRS   = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;
  localparam int Q_DEPTH    = 2;

  localparam logic [VS_W-1:0] VS_RESET = 16'd256;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MESH = 1'b1;

  localparam logic [DIR_W-1:0] DIR_NX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd5;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_PUSH
  } f_state_t;

  // One culled voxel handed from the classifier to the face emitter.
  typedef struct packed {
    logic                clr;
    logic [NUM_DIRS-1:0] faces;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [MAT_W-1:0]    mat;
  } job_t;

endpackage

// File: design/vfcm_ram.sv
module vfcm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/vfcm_queue.sv
module vfcm_queue
  import vfcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PW = $clog2(Q_DEPTH);

  job_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != (PW+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/vfcm_front.sv
module vfcm_front
  import vfcm_pkg::*;
#(
  parameter int CHUNK_SIDE = 32,
  parameter int AW         = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_addr,
  output logic [VOX_W-1:0]     ram_wdata,
  input  logic [VOX_W-1:0]     ram_rdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output job_t                 q_job
);

  localparam int NCW = COORD_W + 1;

  function automatic logic [AW-1:0] addr_of(input logic [NCW-1:0] cx,
                                            input logic [NCW-1:0] cy,
                                            input logic [NCW-1:0] cz);
    addr_of = AW'((int'(cz) * CHUNK_SIDE + int'(cy)) * CHUNK_SIDE + int'(cx));
  endfunction

  f_state_t            state_r, state_nxt;
  logic [COORD_W-1:0]  x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic                clr_r, clr_nxt;
  logic                inside_r, inside_nxt;
  logic [DIR_W-1:0]    dir_r, dir_nxt;
  logic                tag_valid_r, tag_valid_nxt;
  logic                tag_center_r, tag_center_nxt;
  logic [DIR_W-1:0]    tag_dir_r, tag_dir_nxt;
  logic                solid_r, solid_nxt;
  logic [MAT_W-1:0]    mat_r, mat_nxt;
  logic [NUM_DIRS-1:0] mask_r, mask_nxt;

  logic [COORD_W-1:0]  in_x, in_y, in_z;
  logic                in_solid, in_pass_start, in_inside, accept;
  logic [MAT_W-1:0]    in_mat;
  logic [NUM_DIRS-1:0] ok;
  logic [NCW-1:0]      nx, ny, nz;

  assign in_x          = in_tdata[4:0];
  assign in_y          = in_tdata[9:5];
  assign in_z          = in_tdata[14:10];
  assign in_solid      = in_tdata[15];
  assign in_mat        = in_tdata[31:16];
  assign in_pass_start = in_tdata[32];
  assign in_inside     = (int'(in_x) < CHUNK_SIDE) && (int'(in_y) < CHUNK_SIDE) &&
                         (int'(in_z) < CHUNK_SIDE);

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid & in_tready;

  // Neighbors off the chunk edge hide their face.
  always_comb begin
    ok         = '0;
    ok[DIR_NX] = (x_r != '0);
    ok[DIR_PX] = (int'(x_r) + 1 < CHUNK_SIDE);
    ok[DIR_NY] = (y_r != '0);
    ok[DIR_PY] = (int'(y_r) + 1 < CHUNK_SIDE);
    ok[DIR_NZ] = (z_r != '0);
    ok[DIR_PZ] = (int'(z_r) + 1 < CHUNK_SIDE);
  end

  // Stay on the center voxel when the neighbor is off the chunk.
  always_comb begin
    nx = {1'b0, x_r};
    ny = {1'b0, y_r};
    nz = {1'b0, z_r};
    case (dir_r)
      DIR_NX: if (ok[DIR_NX]) nx = nx - NCW'(1);
      DIR_PX: if (ok[DIR_PX]) nx = nx + NCW'(1);
      DIR_NY: if (ok[DIR_NY]) ny = ny - NCW'(1);
      DIR_PY: if (ok[DIR_PY]) ny = ny + NCW'(1);
      DIR_NZ: if (ok[DIR_NZ]) nz = nz - NCW'(1);
      DIR_PZ: if (ok[DIR_PZ]) nz = nz + NCW'(1);
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = accept & (in_tuser == REQ_LOAD) & in_inside;
    ram_wdata = {in_solid, in_mat};
    if (state_r == F_IDLE) begin
      ram_addr = addr_of({1'b0, in_x}, {1'b0, in_y}, {1'b0, in_z});
    end else begin
      ram_addr = addr_of(nx, ny, nz);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    clr_nxt        = clr_r;
    inside_nxt     = inside_r;
    dir_nxt        = dir_r;
    solid_nxt      = solid_r;
    mat_nxt        = mat_r;
    mask_nxt       = mask_r;
    tag_valid_nxt  = 1'b0;
    tag_center_nxt = 1'b0;
    tag_dir_nxt    = dir_r;
    q_valid        = 1'b0;

    // Read data returns in the cycle after its address.
    if (tag_valid_r) begin
      if (tag_center_r) begin
        solid_nxt = ram_rdata[MAT_W];
        mat_nxt   = ram_rdata[MAT_W-1:0];
      end else begin
        mask_nxt[tag_dir_r] = ok[tag_dir_r] &
                              (!ram_rdata[MAT_W] || (ram_rdata[MAT_W-1:0] != mat_r));
      end
    end

    case (state_r)
      F_IDLE: begin
        if (accept && (in_tuser == REQ_MESH)) begin
          x_nxt          = in_x;
          y_nxt          = in_y;
          z_nxt          = in_z;
          clr_nxt        = in_pass_start;
          inside_nxt     = in_inside;
          solid_nxt      = 1'b0;
          mask_nxt       = '0;
          dir_nxt        = DIR_NX;
          tag_valid_nxt  = in_inside;
          tag_center_nxt = 1'b1;
          state_nxt      = in_inside ? F_READ : F_PUSH;
        end
      end
      F_READ: begin
        tag_valid_nxt = 1'b1;
        if (dir_r == DIR_PZ) begin
          state_nxt = F_PUSH;
        end else begin
          dir_nxt = dir_r + DIR_W'(1);
        end
      end
      F_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    q_job.clr   = clr_r;
    q_job.faces = (inside_r && solid_r) ? mask_nxt : '0;
    q_job.x     = x_r;
    q_job.y     = y_r;
    q_job.z     = z_r;
    q_job.mat   = mat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      tag_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_valid_r <= tag_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    z_r          <= z_nxt;
    clr_r        <= clr_nxt;
    inside_r     <= inside_nxt;
    dir_r        <= dir_nxt;
    tag_center_r <= tag_center_nxt;
    tag_dir_r    <= tag_dir_nxt;
    solid_r      <= solid_nxt;
    mat_r        <= mat_nxt;
    mask_r       <= mask_nxt;
  end

endmodule

// File: design/vfcm_back.sv
module vfcm_back
  import vfcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VS_W-1:0]       voxel_size,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  job_t                  q_job,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic                busy_r, busy_nxt;
  logic [NUM_DIRS-1:0] rem_r, rem_nxt;
  logic [VCOUNT_W-1:0] vc_r, vc_nxt;
  logic [MAT_W-1:0]    mat_r;
  logic [ORIGIN_W-1:0] px_r, py_r, pz_r;
  logic                out_valid_r, out_valid_nxt;
  logic [DIR_W-1:0]    o_dir_r;
  logic [ORIGIN_W-1:0] o_x_r, o_y_r, o_z_r;
  logic [MAT_W-1:0]    o_mat_r;
  logic [VCOUNT_W-1:0] o_base_r;
  logic                o_last_r;

  logic                pop, emit, last;
  logic [DIR_W-1:0]    sel_dir;
  logic [NUM_DIRS-1:0] sel_bit;
  logic [ORIGIN_W-1:0] vs_ext;

  assign vs_ext  = ORIGIN_W'(voxel_size);
  assign q_ready = !busy_r;
  assign pop     = q_valid & !busy_r;
  assign emit    = busy_r & (!out_valid_r | out_tready);

  // Lowest remaining face goes first: -X, +X, -Y, +Y, -Z, +Z.
  always_comb begin
    sel_dir = DIR_NX;
    sel_bit = '0;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        sel_dir = DIR_W'(i);
      end
    end
    sel_bit[sel_dir] = 1'b1;
    last = ((rem_r & ~sel_bit) == '0);
  end

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    vc_nxt        = vc_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      rem_nxt  = q_job.faces;
      busy_nxt = (q_job.faces != '0);
      if (q_job.clr) begin
        vc_nxt = '0;
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      rem_nxt       = rem_r & ~sel_bit;
      busy_nxt      = !last;
      vc_nxt        = vc_r + VCOUNT_W'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      vc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      vc_r        <= vc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (pop) begin
      mat_r <= q_job.mat;
      px_r  <= ORIGIN_W'(q_job.x) * vs_ext;
      py_r  <= ORIGIN_W'(q_job.y) * vs_ext;
      pz_r  <= ORIGIN_W'(q_job.z) * vs_ext;
    end
    if (emit) begin
      o_dir_r  <= sel_dir;
      o_x_r    <= px_r + ((sel_dir == DIR_PX) ? vs_ext : '0);
      o_y_r    <= py_r + ((sel_dir == DIR_PY) ? vs_ext : '0);
      o_z_r    <= pz_r + ((sel_dir == DIR_PZ) ? vs_ext : '0);
      o_mat_r  <= mat_r;
      o_base_r <= vc_r;
      o_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_base_r, o_mat_r, o_z_r, o_y_r, o_x_r, o_dir_r};

endmodule

// File: design/voxel_face_culling_mesher_unit.sv
// Voxel face-culling mesher.
// in_* channel: one beat per request. in_tuser selects load (0) or mesh (1). A load writes
// the solid flag and material of one voxel into the chunk store. A mesh beat reads the
// named voxel and its six neighbors and queues the set of exposed faces.
// out_* channel: one beat per exposed face, -X,+X,-Y,+Y,-Z,+Z order, out_tlast on the final
// face of a voxel. Air voxels, coordinates off the chunk and fully hidden voxels give none.
// cfg_we/cfg_wdata write the voxel edge length (unsigned Q8.8); write it only while idle.
// A load leaves the classifier ready for the next beat; a mesh beat holds in_tready low
// through the seven reads on the single port of the voxel store (center plus six neighbors)
// and the queue push. While out_tready is high the faces of a voxel leave one per cycle. A
// two-entry queue parts the classifier from the face emitter, so new beats are taken
// while faces still wait at the output register.
// Reset clears the vertex counter, the queue and the handshakes and sets voxel size to 1.0;
// the voxel store is not cleared, so a voxel must be loaded before it is meshed.
// While out_tready is low the face beat holds; the emitter and then the queue fill and
// in_tready drops once a finished mesh beat has nowhere to go.
module voxel_face_culling_mesher_unit
  import vfcm_pkg::*;
#(
  parameter int CHUNK_SIDE = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // req_type
  // coord_x, coord_y, coord_z, solid_in, material_in, pass_start, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // face_dir, origin_x, origin_y, origin_z, face_material, base_vertex, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // last_face
  input  logic                  cfg_we,
  input  logic [VS_W-1:0]       cfg_wdata
);

  localparam int DEPTH = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [VS_W-1:0]  vs_r;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [VOX_W-1:0] ram_wdata, ram_rdata;
  logic             q_push, q_push_ready, q_pop, q_pop_ready;
  job_t             q_push_job, q_pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= VS_RESET;
    end else if (cfg_we) begin
      vs_r <= cfg_wdata;
    end
  end

  vfcm_ram #(
    .WIDTH(VOX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  vfcm_front #(
    .CHUNK_SIDE(CHUNK_SIDE),
    .AW        (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata),
    .q_valid  (q_push),
    .q_ready  (q_push_ready),
    .q_job    (q_push_job)
  );

  vfcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push),
    .push_ready(q_push_ready),
    .push_job  (q_push_job),
    .pop_valid (q_pop),
    .pop_ready (q_pop_ready),
    .pop_job   (q_pop_job)
  );

  vfcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .voxel_size(vs_r),
    .q_valid   (q_pop),
    .q_ready   (q_pop_ready),
    .q_job     (q_pop_job),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

`ifndef SYNTHESIS
  a_store_write_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_tvalid && in_tready))
    else $error("voxel store written without an accepted load beat");

  a_mesh_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == REQ_MESH)) |=> !in_tready)
    else $error("input taken while a mesh beat is still reading neighbors");

  a_faces_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("gap inside the faces of one voxel");
`endif

endmodule
